// ===== hw/rtl/hxd_pkg.sv =====
package hxd_pkg;

  localparam int ADDR_W         = 32;
  localparam int DATA_W         = 8;
  localparam int LINE_LEN       = 16;
  localparam int POS_W          = 4;
  localparam int CNT_W          = 6;
  localparam int ADDRESS_DIGITS = 8;

  localparam logic [DATA_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [DATA_W-1:0] CHAR_BAR     = 8'h7c;
  localparam logic [DATA_W-1:0] CHAR_DOT     = 8'h2e;
  localparam logic [DATA_W-1:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [DATA_W-1:0] CHAR_TILDE   = 8'h7e;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              flush;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] ascii_char;
    logic              last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_SEP,
    ST_HEX_HI,
    ST_HEX_LO,
    ST_SPACE,
    ST_PAD,
    ST_BAR_OPEN,
    ST_TEXT,
    ST_BAR_CLOSE,
    ST_NEWLINE
  } state_t;

  typedef enum logic [2:0] {
    CH_ADDR,
    CH_SPACE,
    CH_HEX_HI,
    CH_HEX_LO,
    CH_BAR,
    CH_TEXT,
    CH_NEWLINE
  } char_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    char_sel_t sel;
    logic      last;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      pos_inc;
    logic      line_end;
  } cmd_t;

  typedef struct packed {
    logic in_flush;
    logic pos_zero;
    logic pos_mid;
    logic pos_full;
    logic cnt_one;
    logic addr_done;
    logic pad_done;
    logic text_done;
    logic out_free;
  } status_t;

  function automatic logic [DATA_W-1:0] hex_char(input logic [3:0] nib);
    logic [DATA_W-1:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

  function automatic logic [DATA_W-1:0] shown_char(input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] c;
    if (b >= CHAR_SPACE && b <= CHAR_TILDE) begin
      c = b;
    end else begin
      c = CHAR_DOT;
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/hxd_ctrl.sv =====
module hxd_ctrl
  import hxd_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t st,
  output cmd_t    cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = CH_SPACE;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.cnt_clr = 1'b1;
          if (st.in_flush) begin
            state_nxt = st.pos_zero ? ST_IDLE : ST_PAD;
          end else begin
            state_nxt = st.pos_zero ? ST_ADDR : ST_HEX_HI;
          end
        end
      end
      ST_ADDR: begin
        cmd.sel  = CH_ADDR;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          if (st.addr_done) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_SEP;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_SEP: begin
        cmd.sel  = CH_SPACE;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          if (st.cnt_one) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_HEX_HI;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_HEX_HI: begin
        cmd.sel  = CH_HEX_HI;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          state_nxt = ST_HEX_LO;
        end
      end
      ST_HEX_LO: begin
        cmd.sel  = CH_HEX_LO;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          state_nxt = ST_SPACE;
        end
      end
      ST_SPACE: begin
        cmd.sel  = CH_SPACE;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          if (st.cnt_one || !st.pos_mid) begin
            cmd.cnt_clr = 1'b1;
            if (st.pos_full) begin
              state_nxt = ST_BAR_OPEN;
            end else begin
              cmd.last    = 1'b1;
              cmd.pos_inc = 1'b1;
              state_nxt   = ST_IDLE;
            end
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_PAD: begin
        cmd.sel  = CH_SPACE;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          if (st.pad_done) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_BAR_OPEN;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_BAR_OPEN: begin
        cmd.sel  = CH_BAR;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          state_nxt = ST_TEXT;
        end
      end
      ST_TEXT: begin
        cmd.sel  = CH_TEXT;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          if (st.text_done) begin
            cmd.cnt_clr = 1'b1;
            state_nxt   = ST_BAR_CLOSE;
          end else begin
            cmd.cnt_inc = 1'b1;
          end
        end
      end
      ST_BAR_CLOSE: begin
        cmd.sel  = CH_BAR;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          state_nxt = ST_NEWLINE;
        end
      end
      ST_NEWLINE: begin
        cmd.sel  = CH_NEWLINE;
        cmd.emit = st.out_free;
        if (st.out_free) begin
          cmd.last     = 1'b1;
          cmd.line_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hxd_datapath.sv =====
module hxd_datapath
  import hxd_pkg::*;
#(
  parameter int ADDRESS_DIGITS = hxd_pkg::ADDRESS_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data,
  input  cmd_t              cmd,
  output status_t           st
);

  logic [ADDR_W-1:0] line_addr_r;
  logic [POS_W-1:0]  pos_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] data_r;
  logic              flush_r;
  logic [DATA_W-1:0] line_buf_r [LINE_LEN];
  logic              out_valid_r;
  logic [DATA_W-1:0] out_char_r;
  logic              out_last_r;

  logic [CNT_W-1:0]  dig_idx;
  logic [3:0]        addr_nib;
  logic [CNT_W-1:0]  pos_ext;
  logic [CNT_W-1:0]  pad_last;
  logic [POS_W-1:0]  text_last;
  logic [DATA_W-1:0] char_nxt;

  always_comb begin
    dig_idx = CNT_W'(ADDRESS_DIGITS - 1) - cnt_r;
    if (dig_idx < CNT_W'(ADDR_W / 4)) begin
      addr_nib = line_addr_r[{dig_idx[2:0], 2'b00} +: 4];
    end else begin
      addr_nib = 4'd0;
    end
    pos_ext   = {{(CNT_W - POS_W){1'b0}}, pos_r};
    pad_last  = CNT_W'(3 * LINE_LEN) - pos_ext - pos_ext - pos_ext
              + ((pos_r < 4'd8) ? CNT_W'(1) : CNT_W'(0));
    text_last = flush_r ? (pos_r - 4'd1) : pos_r;
  end

  always_comb begin
    st.in_flush  = in_data.flush;
    st.pos_zero  = (pos_r == 4'd0);
    st.pos_mid   = (pos_r == 4'd7) || (pos_r == 4'd15);
    st.pos_full  = (pos_r == 4'd15);
    st.cnt_one   = (cnt_r == CNT_W'(1));
    st.addr_done = (cnt_r == CNT_W'(ADDRESS_DIGITS - 1));
    st.pad_done  = (cnt_r == pad_last);
    st.text_done = (cnt_r[POS_W-1:0] == text_last);
    st.out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    case (cmd.sel)
      CH_ADDR:    char_nxt = hex_char(addr_nib);
      CH_SPACE:   char_nxt = CHAR_SPACE;
      CH_HEX_HI:  char_nxt = hex_char(data_r[7:4]);
      CH_HEX_LO:  char_nxt = hex_char(data_r[3:0]);
      CH_BAR:     char_nxt = CHAR_BAR;
      CH_TEXT:    char_nxt = shown_char(line_buf_r[cnt_r[POS_W-1:0]]);
      CH_NEWLINE: char_nxt = CHAR_NEWLINE;
      default:    char_nxt = CHAR_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_addr_r <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        line_addr_r <= cfg_wr_data;
      end else if (cmd.line_end && !flush_r) begin
        line_addr_r <= line_addr_r + ADDR_W'(LINE_LEN);
      end
      if (cmd.line_end) begin
        pos_r <= '0;
      end else if (cmd.pos_inc) begin
        pos_r <= pos_r + 4'd1;
      end
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r  <= in_data.data_byte;
      flush_r <= in_data.flush;
      if (!in_data.flush) begin
        line_buf_r[pos_r] <= in_data.data_byte;
      end
    end
    if (cmd.emit) begin
      out_char_r <= char_nxt;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.ascii_char = out_char_r;
  assign out_data.last       = out_last_r;

endmodule

// ===== hw/rtl/hexdump_line_encoder_unit.sv =====
// Each accepted item is turned fully into characters before in_ready is raised again.
// A data byte gives 3 or 4 characters, ADDRESS_DIGITS + 2 more at line start, 19 more at line end.
// A flush gives up to 51 characters, or none at line start; the first one passes the state register
// into the single output register, which sets the pace at one per cycle while out_ready is high.
// Synchronous active-low reset returns the block to line start with line address zero.
module hexdump_line_encoder_unit
  import hxd_pkg::*;
#(
  parameter int ADDRESS_DIGITS = hxd_pkg::ADDRESS_DIGITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_wr_en,
  input  logic [ADDR_W-1:0] cfg_wr_data
);

  cmd_t    cmd;
  status_t st;

  hxd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  hxd_datapath #(
    .ADDRESS_DIGITS (ADDRESS_DIGITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .st          (st)
  );

`ifndef NO_ASSERTIONS
  a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_data.flush) |=> !in_ready)
    else $error("Block ready again right after a data byte transfer.");

  a_char_printable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.ascii_char >= CHAR_SPACE && out_data.ascii_char <= CHAR_TILDE)
                   || out_data.ascii_char == CHAR_NEWLINE))
    else $error("Output character is neither printable nor a newline.");

  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last) |->
      (out_data.ascii_char == CHAR_SPACE || out_data.ascii_char == CHAR_NEWLINE))
    else $error("Final character of an item is not a space or a newline.");
`endif

endmodule

// ===== sim/hexdump_line_encoder_unit_tb.sv =====
`timescale 1ns / 1ps

module hexdump_line_encoder_unit_tb;
  import hxd_pkg::*;

  localparam int LONG_STALL   = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int IDLE_LIMIT   = 4000;
  localparam string HEX_DIGITS = "0123456789abcdef";

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;
  logic              cfg_wr_en = 1'b0;
  logic [ADDR_W-1:0] cfg_wr_data = '0;

  in_item_t    pending_items[$];
  out_item_t   expected_chars[$];
  logic [7:0]  line_chars[$];

  logic [ADDR_W-1:0] line_addr = '0;
  int                line_pos = 0;
  logic [7:0]        line_bytes[LINE_LEN];

  int mismatches = 0;
  int inputs_taken = 0;
  int flushes_taken = 0;
  int chars_checked = 0;
  int settings_used = 0;
  int burst_left = 1;
  int gap_left = 0;
  int rx_cycle = 0;
  int rx_mode = 0;
  int stall_left = 0;
  int next_long_stall = 300;
  int idle_cycles = 0;

  logic [7:0] corner_bytes[6] = '{8'h00, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'hff};

  hexdump_line_encoder_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 20) begin
      $display("MISMATCH at %0t: %s", $realtime, msg);
    end
  endtask

  task automatic close_line(input int count);
    line_chars.push_back(CHAR_BAR);
    for (int i = 0; i < count; i++) begin
      line_chars.push_back((line_bytes[i] >= 8'h20 && line_bytes[i] <= 8'h7e) ?
                           line_bytes[i] : CHAR_DOT);
    end
    line_chars.push_back(CHAR_BAR);
    line_chars.push_back(CHAR_NEWLINE);
  endtask

  task automatic encode_item(input in_item_t item);
    int pad;
    int sh;
    logic [3:0] nib;
    line_chars.delete();
    if (item.flush) begin
      if (line_pos != 0) begin
        pad = 3 * (LINE_LEN - line_pos) + ((line_pos < 8) ? 1 : 0) + 1;
        repeat (pad) line_chars.push_back(CHAR_SPACE);
        close_line(line_pos);
        line_pos = 0;
      end
    end else begin
      if (line_pos == 0) begin
        for (int i = ADDRESS_DIGITS - 1; i >= 0; i--) begin
          sh = 4 * i;
          nib = (sh < ADDR_W) ? 4'((line_addr >> sh) & 32'hf) : 4'h0;
          line_chars.push_back(HEX_DIGITS[nib]);
        end
        line_chars.push_back(CHAR_SPACE);
        line_chars.push_back(CHAR_SPACE);
      end
      line_bytes[line_pos] = item.data_byte;
      line_chars.push_back(HEX_DIGITS[item.data_byte[7:4]]);
      line_chars.push_back(HEX_DIGITS[item.data_byte[3:0]]);
      line_chars.push_back(CHAR_SPACE);
      if (line_pos == 7 || line_pos == 15) begin
        line_chars.push_back(CHAR_SPACE);
      end
      line_pos++;
      if (line_pos == LINE_LEN) begin
        close_line(LINE_LEN);
        line_addr = line_addr + 32'd16;
        line_pos = 0;
      end
    end
    foreach (line_chars[i]) begin
      expected_chars.push_back(out_item_t'{ascii_char: line_chars[i],
                                           last: (i == line_chars.size() - 1)});
    end
  endtask

  always @(posedge clk) begin : driver
    if (rst_n) begin
      if (in_valid && in_ready) begin
        encode_item(in_data);
        inputs_taken++;
        if (in_data.flush) begin
          flushes_taken++;
        end
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          flag_mismatch($sformatf("unexpected character %02h last %0b",
                                  out_data.ascii_char, out_data.last));
        end else begin
          want = expected_chars.pop_front();
          if (out_data.ascii_char !== want.ascii_char || out_data.last !== want.last) begin
            flag_mismatch($sformatf("character %02h last %0b, expected %02h last %0b",
                                    out_data.ascii_char, out_data.last,
                                    want.ascii_char, want.last));
          end
          chars_checked++;
        end
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) begin
        rx_mode = $urandom_range(0, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (chars_checked >= next_long_stall) begin
        stall_left = LONG_STALL;
        next_long_stall += 700;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_cycle % 7 != 3) && (rx_cycle % 7 != 4);
        endcase
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d characters still awaited.",
                 IDLE_LIMIT, expected_chars.size());
        $display("hexdump_line_encoder_unit_tb NOT OK");
        $finish;
      end
    end
  end

  task automatic push_byte(input logic [7:0] value);
    pending_items.push_back(in_item_t'{data_byte: value, flush: 1'b0});
  endtask

  task automatic push_flush();
    pending_items.push_back(in_item_t'{data_byte: 8'($urandom_range(0, 255)), flush: 1'b1});
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        push_flush();
      end else if ($urandom_range(0, 7) == 0) begin
        push_byte(corner_bytes[$urandom_range(0, 5)]);
      end else begin
        push_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_items.size() != 0 || in_valid || expected_chars.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_address(input logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    line_addr = value;
    settings_used++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  logic [7:0] first_line[16] = '{8'h00, 8'hff, 8'h1f, 8'h20, 8'h7e, 8'h7f, 8'h80, 8'h41,
                                 8'h7a, 8'h30, 8'h0f, 8'hf0, 8'h5a, 8'ha5, 8'h09, 8'h0a};

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_start_address(32'hffff_fff0);

    push_flush();
    foreach (first_line[i]) begin
      push_byte(first_line[i]);
    end
    for (int i = 0; i < 8; i++) begin
      push_byte(8'h61 + 8'(i));
    end
    push_flush();
    wait_idle();

    for (int i = 0; i < 5; i++) begin
      push_byte(8'($urandom_range(0, 255)));
    end
    wait_idle();
    write_start_address(32'hffff_ffff);
    for (int i = 0; i < 11; i++) begin
      push_byte(8'($urandom_range(0, 255)));
    end
    queue_random(70);
    wait_idle();

    write_start_address(32'h0000_0000);
    queue_random(60);
    wait_idle();

    write_start_address(32'($urandom()));
    queue_random(50);
    push_flush();
    wait_idle();

    $display("Checked %0d output characters from %0d input transfers (%0d flushes).",
             chars_checked, inputs_taken, flushes_taken);
    $display("Used %0d start address settings, including mid-line writes and wraparound.",
             settings_used);
    if (mismatches == 0) begin
      $display("hexdump_line_encoder_unit_tb OK");
    end else begin
      $display("hexdump_line_encoder_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== hexdump_line_encoder_unit.f =====
hw/rtl/hxd_pkg.sv
hw/rtl/hxd_ctrl.sv
hw/rtl/hxd_datapath.sv
hw/rtl/hexdump_line_encoder_unit.sv
sim/hexdump_line_encoder_unit_tb.sv
